### rtl/csvfs_pkg.sv
// csvfs_pkg: shared types and character codes for the CSV field splitter.
// Used by csvfs_ctrl, csvfs_datapath and csv_field_splitter; no dependencies.
package csvfs_pkg;

    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] SEP_RESET = 8'h2C;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_FLUSH,
        ST_CHAR,
        ST_LEND
    } state_t;

    // controller -> datapath
    typedef struct packed {
        logic load;
        logic flush_step;
        logic char_step;
        logic lend_step;
    } cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic in_term;
        logic in_plain;
        logic in_last;
        logic item_last;
        logic held_nz;
        logic held_one;
        logic out_free;
    } sts_t;

endpackage

### rtl/csvfs_ctrl.sv
// csvfs_ctrl: sequencer for the CSV field splitter (accept, flush held CR/LF,
// character, line end). Depends on csvfs_pkg.
module csvfs_ctrl
    import csvfs_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic s_valid,
    output logic s_ready,
    input  sts_t sts,
    output cmd_t cmd
);

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    priority if (sts.in_plain) begin
                        state_next = sts.held_nz ? ST_FLUSH : ST_CHAR;
                    end else if (sts.in_last) begin
                        state_next = ST_LEND;
                    end else begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_FLUSH: begin
                if (sts.out_free && sts.held_one) begin
                    state_next = ST_CHAR;
                end
            end
            ST_CHAR: begin
                if (sts.out_free) begin
                    state_next = sts.item_last ? ST_LEND : ST_IDLE;
                end
            end
            ST_LEND: begin
                if (sts.out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        s_ready        = 1'b0;
        cmd            = '0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready  = 1'b1;
                cmd.load = s_valid;
            end
            ST_FLUSH: cmd.flush_step = sts.out_free;
            ST_CHAR:  cmd.char_step  = sts.out_free;
            ST_LEND:  cmd.lend_step  = sts.out_free;
            default: cmd = '0;
        endcase
    end

endmodule

### rtl/csvfs_datapath.sv
// csvfs_datapath: item registers, quote state, held CR/LF store, cell counters
// and the result output register. Depends on csvfs_pkg; driven by csvfs_ctrl.
module csvfs_datapath
    import csvfs_pkg::*;
#(
    parameter int TERM_DEPTH = 8,
    parameter int COUNT_BITS = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [7:0]  cfg_wr_data,
    input  logic        s_has_byte,
    input  logic [7:0]  s_in_byte,
    input  logic        s_line_last,
    input  logic        m_ready,
    output logic        m_valid,
    output logic [7:0]  m_out_byte,
    output logic        m_byte_valid,
    output logic        m_cell_end,
    output logic        m_line_end,
    output logic [15:0] m_cells_in_line,
    output logic [15:0] m_max_cells,
    output logic        m_term_overflow,
    output logic        m_run_last,
    input  cmd_t        cmd,
    output sts_t        sts
);

    localparam int CNT_W = $clog2(TERM_DEPTH + 1);

    logic [7:0]            sep_reg;
    logic [7:0]            item_byte_reg;
    logic                  item_last_reg;
    logic                  inq_reg, inq_next;
    logic                  pend_reg, pend_next;
    logic                  ovf_reg, ovf_next;
    logic [CNT_W-1:0]      held_cnt_reg, held_cnt_next;
    logic [TERM_DEPTH-1:0] kinds_reg, kinds_next;
    logic [COUNT_BITS-1:0] line_cnt_reg, line_cnt_next;
    logic [COUNT_BITS-1:0] max_cnt_reg, max_cnt_next;

    logic                  m_valid_reg, m_valid_next;
    logic [7:0]            o_byte_reg, o_byte_next;
    logic                  o_bv_reg, o_bv_next;
    logic                  o_ce_reg, o_ce_next;
    logic                  o_le_reg, o_le_next;
    logic [15:0]           o_cells_reg, o_cells_next;
    logic [15:0]           o_max_reg, o_max_next;
    logic                  o_ovf_reg, o_ovf_next;
    logic                  o_rl_reg, o_rl_next;

    logic                  in_term;
    logic                  out_free;
    logic                  char_emits;
    logic                  eff_inq;
    logic [7:0]            flush_ch;
    logic [COUNT_BITS-1:0] line_inc;
    logic [COUNT_BITS-1:0] cells_sel;
    logic [COUNT_BITS-1:0] max_sel;
    logic [31:0]           cells_wide;
    logic [31:0]           max_wide;
    logic                  emit;

    assign in_term    = s_has_byte && (s_in_byte == CH_CR || s_in_byte == CH_LF);
    assign out_free   = !m_valid_reg || m_ready;
    assign char_emits = !(item_byte_reg == CH_QUOTE && !pend_reg);
    assign eff_inq    = pend_reg ? 1'b0 : inq_reg;
    assign flush_ch   = kinds_reg[0] ? CH_LF : CH_CR;
    assign line_inc   = (line_cnt_reg == '1) ? line_cnt_reg : line_cnt_reg + 1'b1;

    assign sts.in_term   = in_term;
    assign sts.in_plain  = s_has_byte && !in_term;
    assign sts.in_last   = s_line_last;
    assign sts.item_last = item_last_reg;
    assign sts.held_nz   = held_cnt_reg != '0;
    assign sts.held_one  = held_cnt_reg == CNT_W'(1);
    assign sts.out_free  = out_free;

    always_comb begin
        inq_next      = inq_reg;
        pend_next     = pend_reg;
        ovf_next      = ovf_reg;
        held_cnt_next = held_cnt_reg;
        kinds_next    = kinds_reg;
        line_cnt_next = line_cnt_reg;
        max_cnt_next  = max_cnt_reg;
        emit          = 1'b0;
        o_byte_next   = 8'd0;
        o_bv_next     = 1'b0;
        o_ce_next     = 1'b0;
        o_le_next     = 1'b0;
        o_rl_next     = 1'b0;
        cells_sel     = line_cnt_reg;
        max_sel       = max_cnt_reg;
        if (cmd.load) begin
            if (in_term) begin
                // a pending quote is closed by the CR/LF
                if (pend_reg) begin
                    pend_next = 1'b0;
                    inq_next  = 1'b0;
                end
                if (held_cnt_reg < CNT_W'(TERM_DEPTH)) begin
                    for (int i = 0; i < TERM_DEPTH; i++) begin
                        if (held_cnt_reg == CNT_W'(i)) begin
                            kinds_next[i] = (s_in_byte == CH_LF);
                        end
                    end
                    held_cnt_next = held_cnt_reg + 1'b1;
                end else begin
                    ovf_next = 1'b1;
                end
            end
        end else if (cmd.flush_step) begin
            emit          = 1'b1;
            kinds_next    = kinds_reg >> 1;
            held_cnt_next = held_cnt_reg - 1'b1;
            o_rl_next     = (held_cnt_reg == CNT_W'(1)) && !char_emits && !item_last_reg;
            if (flush_ch == sep_reg && !inq_reg) begin
                line_cnt_next = line_inc;
                cells_sel     = line_inc;
                o_ce_next     = 1'b1;
            end else begin
                o_byte_next = flush_ch;
                o_bv_next   = 1'b1;
            end
        end else if (cmd.char_step) begin
            held_cnt_next = '0;
            o_rl_next     = !item_last_reg;
            if (item_byte_reg == CH_QUOTE) begin
                priority if (pend_reg) begin
                    // doubled quote inside quotes
                    pend_next   = 1'b0;
                    emit        = 1'b1;
                    o_byte_next = CH_QUOTE;
                    o_bv_next   = 1'b1;
                end else if (!inq_reg) begin
                    inq_next = 1'b1;
                end else begin
                    pend_next = 1'b1;
                end
            end else begin
                pend_next = 1'b0;
                inq_next  = eff_inq;
                emit      = 1'b1;
                if (item_byte_reg == sep_reg && !eff_inq) begin
                    line_cnt_next = line_inc;
                    cells_sel     = line_inc;
                    o_ce_next     = 1'b1;
                end else begin
                    o_byte_next = item_byte_reg;
                    o_bv_next   = 1'b1;
                end
            end
        end else if (cmd.lend_step) begin
            held_cnt_next = '0;
            pend_next     = 1'b0;
            inq_next      = 1'b0;
            line_cnt_next = '0;
            cells_sel     = line_inc;
            if (line_inc > max_cnt_reg) begin
                max_cnt_next = line_inc;
                max_sel      = line_inc;
            end
            emit      = 1'b1;
            o_ce_next = 1'b1;
            o_le_next = 1'b1;
            o_rl_next = 1'b1;
        end
    end

    assign cells_wide   = 32'(cells_sel);
    assign max_wide     = 32'(max_sel);
    assign o_cells_next = cells_wide[15:0];
    assign o_max_next   = max_wide[15:0];
    assign o_ovf_next   = ovf_next;

    always_comb begin
        m_valid_next = m_valid_reg;
        if (emit) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sep_reg      <= SEP_RESET;
            inq_reg      <= 1'b0;
            pend_reg     <= 1'b0;
            ovf_reg      <= 1'b0;
            held_cnt_reg <= '0;
            line_cnt_reg <= '0;
            max_cnt_reg  <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                sep_reg <= cfg_wr_data;
            end
            inq_reg      <= inq_next;
            pend_reg     <= pend_next;
            ovf_reg      <= ovf_next;
            held_cnt_reg <= held_cnt_next;
            line_cnt_reg <= line_cnt_next;
            max_cnt_reg  <= max_cnt_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    // payload: no reset
    always_ff @(posedge aclk) begin
        kinds_reg <= kinds_next;
        if (cmd.load) begin
            item_byte_reg <= s_in_byte;
            item_last_reg <= s_line_last;
        end
        if (emit) begin
            o_byte_reg  <= o_byte_next;
            o_bv_reg    <= o_bv_next;
            o_ce_reg    <= o_ce_next;
            o_le_reg    <= o_le_next;
            o_cells_reg <= o_cells_next;
            o_max_reg   <= o_max_next;
            o_ovf_reg   <= o_ovf_next;
            o_rl_reg    <= o_rl_next;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_out_byte      = o_byte_reg;
    assign m_byte_valid    = o_bv_reg;
    assign m_cell_end      = o_ce_reg;
    assign m_line_end      = o_le_reg;
    assign m_cells_in_line = o_cells_reg;
    assign m_max_cells     = o_max_reg;
    assign m_term_overflow = o_ovf_reg;
    assign m_run_last      = o_rl_reg;

endmodule

### rtl/csv_field_splitter.sv
// csv_field_splitter: quoted CSV tokenizer, at most one raw byte per input beat.
// Results are registered in the output register by flush, character and line end steps.
// A CR/LF or empty beat is taken in idle alone; any other byte also takes a flush step per
// held CR/LF and a character step; line_last adds a line end step; at most one result
// per cycle. Output stalls hold a step; the sequencer takes a new beat only between items.
// Reset: synchronous, active low; clears quote state, counters, flag; separator to ','.
module csv_field_splitter
    import csvfs_pkg::*;
#(
    parameter int TERM_DEPTH = 8,
    parameter int COUNT_BITS = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [7:0]  cfg_wr_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_has_byte,
    input  logic [7:0]  s_in_byte,
    input  logic        s_line_last,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_out_byte,
    output logic        m_byte_valid,
    output logic        m_cell_end,
    output logic        m_line_end,
    output logic [15:0] m_cells_in_line,
    output logic [15:0] m_max_cells,
    output logic        m_term_overflow,
    output logic        m_run_last
);

    cmd_t cmd;
    sts_t sts;

    csvfs_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    csvfs_datapath #(
        .TERM_DEPTH (TERM_DEPTH),
        .COUNT_BITS (COUNT_BITS)
    ) u_dp (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_wr_data     (cfg_wr_data),
        .s_has_byte      (s_has_byte),
        .s_in_byte       (s_in_byte),
        .s_line_last     (s_line_last),
        .m_ready         (m_ready),
        .m_valid         (m_valid),
        .m_out_byte      (m_out_byte),
        .m_byte_valid    (m_byte_valid),
        .m_cell_end      (m_cell_end),
        .m_line_end      (m_line_end),
        .m_cells_in_line (m_cells_in_line),
        .m_max_cells     (m_max_cells),
        .m_term_overflow (m_term_overflow),
        .m_run_last      (m_run_last),
        .cmd             (cmd),
        .sts             (sts)
    );

    // line end beat always closes a cell and ends the run
    a_lend_closes: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_line_end |-> m_cell_end && m_run_last)
        else $error("line end beat without cell end or run end");

    a_byte_not_cell: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_byte_valid |-> !m_cell_end)
        else $error("content byte and cell end on one beat");

    // accepting a plain byte always takes the sequencer out of idle, so s_ready drops
    a_plain_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_has_byte && s_in_byte != CH_CR && s_in_byte != CH_LF
        |=> !s_ready)
        else $error("plain byte accepted without processing cycle");

    a_sts_plain: assert property (@(posedge aclk) disable iff (!aresetn)
        sts.in_plain |-> !sts.in_term && s_has_byte)
        else $error("byte classed both plain and terminator");

endmodule
